// File: sv/cicp_pkg.sv
// ----------------------------------------------------------------------------
// cicp_pkg
// Types, port codes and priority helpers for the cascaded controller pair.
// ----------------------------------------------------------------------------
package cicp_pkg;

  typedef enum logic [1:0] {
    OP_IO_WRITE = 2'd0,
    OP_IO_READ  = 2'd1,
    OP_LINE_CHG = 2'd2,
    OP_INT_ACK  = 2'd3
  } op_t;

  localparam logic [15:0] PORT_M_CMD  = 16'h0020;
  localparam logic [15:0] PORT_M_DATA = 16'h0021;
  localparam logic [15:0] PORT_S_CMD  = 16'h00A0;
  localparam logic [15:0] PORT_S_DATA = 16'h00A1;
  localparam logic [15:0] PORT_M_ELCR = 16'h04D0;
  localparam logic [15:0] PORT_S_ELCR = 16'h04D1;

  localparam logic [7:0] ELCR_MASK_M = 8'hF8;
  localparam logic [7:0] ELCR_MASK_S = 8'hDE;

  // OCW2 command codes in bits 7..5
  localparam logic [2:0] OCW2_EOI     = 3'd1;
  localparam logic [2:0] OCW2_SEOI    = 3'd3;
  localparam logic [2:0] OCW2_ROT_EOI = 3'd5;

  // initialization sequence steps
  localparam logic [1:0] STEP_READY = 2'd0;
  localparam logic [1:0] STEP_ICW2  = 2'd1;
  localparam logic [1:0] STEP_ICW3  = 2'd2;
  localparam logic [1:0] STEP_ICW4  = 2'd3;

  localparam logic [2:0] CASCADE_LINE  = 3'd2;
  localparam logic [2:0] SPURIOUS_LINE = 3'd7;

  typedef struct packed {
    logic [7:0] irr;
    logic [7:0] prev;
    logic [7:0] isr;
    logic [7:0] imr;
    logic [7:0] elcr;
    logic [4:0] vbase;
    logic [2:0] rot;
    logic [1:0] step;
    logic       ic4;
    logic       ris;
  } pic_state_t;

  typedef struct packed {
    op_t         opcode;
    logic [15:0] io_port;
    logic [7:0]  write_data;
    logic [3:0]  irq_line;
    logic        irq_level;
  } item_t;

  typedef struct packed {
    logic       found;
    logic [2:0] rank;
  } rank_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] line;
  } pend_t;

  // Best set bit in rotated priority order, rank 0 highest.
  function automatic rank_t rank_f(input logic [7:0] bits, input logic [2:0] rot);
    rank_t      res;
    logic [7:0] rotated;
    logic [2:0] idx;
    res = '0;
    rotated = '0;
    for (int i = 0; i < 8; i++) begin
      idx = 3'(i) + rot;
      rotated[i] = bits[idx];
    end
    for (int i = 7; i >= 0; i--) begin
      if (rotated[i]) begin
        res.found = 1'b1;
        res.rank  = 3'(i);
      end
    end
    return res;
  endfunction

  function automatic pend_t pending_f(input pic_state_t st);
    pend_t res;
    rank_t rr;
    rank_t cr;
    rr = rank_f(st.irr & ~st.imr, st.rot);
    cr = rank_f(st.isr, st.rot);
    res.valid = rr.found && (!cr.found || (rr.rank < cr.rank));
    res.line  = rr.rank + st.rot;
    return res;
  endfunction

  function automatic pic_state_t drive_f(input pic_state_t st, input logic [2:0] ln,
                                         input logic lvl);
    pic_state_t res;
    logic [7:0] b;
    res = st;
    b = 8'b1 << ln;
    if ((st.elcr & b) != '0) begin
      if (lvl) begin
        res.irr  = st.irr | b;
        res.prev = st.prev | b;
      end else begin
        res.irr  = st.irr & ~b;
        res.prev = st.prev & ~b;
      end
    end else begin
      if (lvl) begin
        if ((st.prev & b) == '0) res.irr = st.irr | b;
        res.prev = st.prev | b;
      end else begin
        res.prev = st.prev & ~b;
      end
    end
    return res;
  endfunction

  function automatic pic_state_t accept_f(input pic_state_t st, input logic [2:0] ln);
    pic_state_t res;
    logic [7:0] b;
    res = st;
    b = 8'b1 << ln;
    res.isr = st.isr | b;
    if ((st.elcr & b) == '0) res.irr = st.irr & ~b;
    return res;
  endfunction

endpackage

// File: sv/cicp_step.sv
// ----------------------------------------------------------------------------
// cicp_step
// Next-state and result logic for one transfer on the controller pair.
// ----------------------------------------------------------------------------
module cicp_step
  import cicp_pkg::*;
(
  input  item_t      item,
  input  pic_state_t m_st,
  input  pic_state_t s_st,
  output pic_state_t m_nxt,
  output pic_state_t s_nxt,
  output logic       int_nxt,
  input  logic       int_cur,
  output logic [7:0] rdata
);

  logic       pic_port;
  logic       elcr_port;
  logic       d;
  logic [7:0] v;
  pic_state_t cur;
  pic_state_t m_w;
  pic_state_t s_w;
  pic_state_t m_ref;
  logic       do_ref;
  rank_t      ir;
  logic [2:0] eoi_line;
  pend_t      mp;
  pend_t      sp;
  pend_t      sp_ref;
  pend_t      mp_ref;
  logic [7:0] edge_req;

  assign pic_port  = (item.io_port == PORT_M_CMD) || (item.io_port == PORT_M_DATA) ||
                     (item.io_port == PORT_S_CMD) || (item.io_port == PORT_S_DATA);
  assign elcr_port = (item.io_port == PORT_M_ELCR) || (item.io_port == PORT_S_ELCR);
  assign d = pic_port ? item.io_port[7] : item.io_port[0];
  assign v = item.write_data;

  always_comb begin
    m_w      = m_st;
    s_w      = s_st;
    cur      = d ? s_st : m_st;
    do_ref   = 1'b0;
    rdata    = '0;
    ir       = '0;
    eoi_line = '0;
    edge_req = '0;
    mp       = pending_f(m_st);
    sp       = pending_f(s_st);
    case (item.opcode)
      OP_IO_WRITE: begin
        if (pic_port) begin
          if (item.io_port[0]) begin
            case (cur.step)
              STEP_READY: begin
                cur.imr = v;
                do_ref  = 1'b1;
              end
              STEP_ICW2: begin
                cur.vbase = v[7:3];
                cur.step  = STEP_ICW3;
              end
              STEP_ICW3: cur.step = cur.ic4 ? STEP_ICW4 : STEP_READY;
              default:   cur.step = STEP_READY;
            endcase
          end else if (v[4]) begin
            edge_req  = cur.irr & ~cur.elcr;
            cur.ic4   = v[0];
            cur.imr   = '0;
            cur.prev  = '0;
            cur.irr   = cur.irr & cur.elcr;
            cur.step  = STEP_ICW2;
            cur.isr   = cur.isr & ~edge_req;
          end else if (v[3]) begin
            if (v[1]) cur.ris = v[0];
          end else begin
            if ((v[7:5] == OCW2_EOI) || (v[7:5] == OCW2_ROT_EOI)) begin
              ir = rank_f(cur.isr, cur.rot);
              if (ir.found) begin
                eoi_line = ir.rank + cur.rot;
                if (v[7:5] == OCW2_ROT_EOI) cur.rot = eoi_line + 3'd1;
                cur.isr = cur.isr & ~(8'b1 << eoi_line);
                do_ref  = 1'b1;
              end
            end else if (v[7:5] == OCW2_SEOI) begin
              cur.isr = cur.isr & ~(8'b1 << v[2:0]);
              do_ref  = 1'b1;
            end
          end
        end else if (elcr_port) begin
          cur.elcr = v & (d ? ELCR_MASK_S : ELCR_MASK_M);
        end
        if (d) s_w = cur;
        else   m_w = cur;
      end
      OP_IO_READ: begin
        if (pic_port) begin
          if (item.io_port[0]) rdata = cur.imr;
          else                 rdata = cur.ris ? cur.isr : cur.irr;
        end else if (elcr_port) begin
          rdata = cur.elcr;
        end
      end
      OP_LINE_CHG: begin
        if (item.irq_line[3]) s_w = drive_f(s_st, item.irq_line[2:0], item.irq_level);
        else                  m_w = drive_f(m_st, item.irq_line[2:0], item.irq_level);
        do_ref = 1'b1;
      end
      default: begin
        if (mp.valid) begin
          m_w = accept_f(m_st, mp.line);
          if (mp.line == CASCADE_LINE) begin
            if (sp.valid) begin
              s_w   = accept_f(s_st, sp.line);
              rdata = {s_st.vbase, sp.line};
            end else begin
              rdata = {s_st.vbase, SPURIOUS_LINE};
            end
          end else begin
            rdata = {m_st.vbase, mp.line};
          end
        end else begin
          rdata = {m_st.vbase, SPURIOUS_LINE};
        end
        do_ref = 1'b1;
      end
    endcase

    // pulse master line 2 when the slave presents, then sample the master
    sp_ref = pending_f(s_w);
    m_ref  = m_w;
    if (sp_ref.valid) begin
      m_ref = drive_f(m_ref, CASCADE_LINE, 1'b1);
      m_ref = drive_f(m_ref, CASCADE_LINE, 1'b0);
    end
    mp_ref = pending_f(m_ref);
    if (do_ref) begin
      m_nxt   = m_ref;
      int_nxt = mp_ref.valid;
    end else begin
      m_nxt   = m_w;
      int_nxt = int_cur;
    end
    s_nxt = s_w;
  end

endmodule

// File: sv/cascaded_interrupt_controller_pair_top.sv
// ----------------------------------------------------------------------------
// cascaded_interrupt_controller_pair_top
// Master/slave 8259-style controller pair driven by a transfer stream.
// ----------------------------------------------------------------------------
// Path: an input transfer enters the input register, then passes once through
//   the step logic into the result register.
// Throughput: one transfer per cycle, set by the single-pass step logic; while
//   the result register is held by out_ready low, in_ready drops once the
//   input register is full.
// Reset: synchronous active-low rst_n clears both controllers, the committed
//   interrupt state and both pipeline valid flags; the block accepts right after.
module cascaded_interrupt_controller_pair_top
  import cicp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_io_port,
  input  logic [7:0]  in_write_data,
  input  logic [3:0]  in_irq_line,
  input  logic        in_irq_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_int_request
);

  // input stage
  logic       s1_valid_r;
  item_t      s1_item_r;
  logic       adv;

  // controller state
  pic_state_t m_r;
  pic_state_t s_r;
  logic       int_r;
  pic_state_t m_nxt;
  pic_state_t s_nxt;
  logic       int_nxt;
  logic [7:0] rdata;

  // result stage
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_int_r;

  // Advance when the result register is empty or being drained this cycle.
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Capture payload on each input transfer; no reset needed.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.opcode     <= op_t'(in_opcode);
      s1_item_r.io_port    <= in_io_port;
      s1_item_r.write_data <= in_write_data;
      s1_item_r.irq_line   <= in_irq_line;
      s1_item_r.irq_level  <= in_irq_level;
    end
  end

  cicp_step u_step (
    .item    (s1_item_r),
    .m_st    (m_r),
    .s_st    (s_r),
    .m_nxt   (m_nxt),
    .s_nxt   (s_nxt),
    .int_nxt (int_nxt),
    .int_cur (int_r),
    .rdata   (rdata)
  );

  // Commit controller state only as an item moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r   <= '0;
      s_r   <= '0;
      int_r <= 1'b0;
    end else if (adv) begin
      m_r   <= m_nxt;
      s_r   <= s_nxt;
      int_r <= int_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the result until the output transfer completes.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= rdata;
      out_int_r  <= int_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_data_r;
  assign out_int_request = out_int_r;

  // A new result appears only from an item that advanced out of the input stage.
  a_out_from_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r) && $past(rst_n)) |-> $past(adv))
    else $error("result valid without an advancing item");

  // A stalled input item stays in the input stage.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input stage lost an item under stall");

  // The delivered request flag matches the committed interrupt output.
  a_int_match: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (out_int_request == int_r))
    else $error("int_request differs from committed interrupt state");

  // Master and slave ELCRs keep only the lines their fixed masks allow.
  a_elcr_mask: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (((m_r.elcr & ~ELCR_MASK_M) == '0) && ((s_r.elcr & ~ELCR_MASK_S) == '0)))
    else $error("ELCR holds a disallowed line");

endmodule
